// ===== src/fcgi_dmx_pkg.sv =====
// Package for the FastCGI record demultiplexer: beat types, parser phases,
// event, record type and role codes. Depends on nothing; every module imports it.
package fcgi_dmx_pkg;

    // Input beat: one transport byte or a connection reset.
    typedef struct packed {
        logic       operation;
        logic [7:0] data_byte;
    } fcgi_in_t;

    // Result beat: one parser event.
    typedef struct packed {
        logic [3:0]  event_res;
        logic [15:0] request_id;
        logic [7:0]  record_type;
        logic [7:0]  payload_byte;
        logic [15:0] role_value;
    } fcgi_out_t;

    // Operation codes of an input beat.
    localparam logic OP_STREAM = 1'b0;
    localparam logic OP_RESET  = 1'b1;

    // Parser phases.
    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_BODY   = 2'd1;
    localparam logic [1:0] PH_PAD    = 2'd2;

    // Byte positions within the eight-byte record header.
    localparam logic [2:0] HB_TYPE    = 3'd1;
    localparam logic [2:0] HB_ID_HI   = 3'd2;
    localparam logic [2:0] HB_ID_LO   = 3'd3;
    localparam logic [2:0] HB_LEN_HI  = 3'd4;
    localparam logic [2:0] HB_LEN_LO  = 3'd5;
    localparam logic [2:0] HB_PAD_LEN = 3'd6;
    localparam logic [2:0] HB_LAST    = 3'd7;

    // Position within a begin-request body.
    localparam logic [1:0] BP_ROLE_HI = 2'd0;
    localparam logic [1:0] BP_ROLE_LO = 2'd1;
    localparam logic [1:0] BP_DONE    = 2'd2;

    // Event codes.
    localparam logic [3:0] EV_STDIN_BYTE  = 4'd0;
    localparam logic [3:0] EV_STDIN_END   = 4'd1;
    localparam logic [3:0] EV_PARAMS_BYTE = 4'd2;
    localparam logic [3:0] EV_PARAMS_END  = 4'd3;
    localparam logic [3:0] EV_UNKNOWN     = 4'd4;
    localparam logic [3:0] EV_ABORT       = 4'd5;
    localparam logic [3:0] EV_REFUSED     = 4'd6;
    localparam logic [3:0] EV_GETVAL      = 4'd7;
    localparam logic [3:0] EV_BEGUN       = 4'd8;

    // Record types.
    localparam logic [7:0] TY_BEGIN  = 8'd1;
    localparam logic [7:0] TY_ABORT  = 8'd2;
    localparam logic [7:0] TY_PARAMS = 8'd4;
    localparam logic [7:0] TY_STDIN  = 8'd5;
    localparam logic [7:0] TY_GETVAL = 8'd9;

    // Roles.
    localparam logic [15:0] ROLE_FILTER = 16'd3;

endpackage

// ===== src/fastcgi_record_demux_unit.sv =====
// Top level of the FastCGI record demultiplexer: input beat register, parser, result register.
// Depends on fcgi_dmx_pkg and fcgi_dmx_parser.
//
//   Channel   Direction  Handshake           Beat
//   s_        in         s_valid / s_ready   fcgi_in_t  (operation, data_byte)
//   m_        out        m_valid / m_ready   fcgi_out_t (event_res .. role_value)
//
// One beat is taken every clock cycle while the result side keeps up. A beat
// is held in the input register until the parser steps; the parser updates its state
// from it in one pass and any event is loaded into the result register at the edge
// at which the parser steps, which raises m_valid.
// Reset is synchronous on aresetn (active low) and empties both registers.
// When m_ready is low with a result waiting, the parser holds and s_ready falls
// once the input register is also full; nothing is lost or repeated.
module fastcgi_record_demux_unit (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  fcgi_dmx_pkg::fcgi_in_t  s_data,
    output logic                    m_valid,
    input  logic                    m_ready,
    output fcgi_dmx_pkg::fcgi_out_t m_data
);
    import fcgi_dmx_pkg::*;

    // Input register: the beat waiting to be parsed.
    logic      in_valid_reg, in_valid_next;
    fcgi_in_t  in_item_reg;

    // Result register: the event waiting to be taken downstream.
    logic      out_valid_reg, out_valid_next;
    fcgi_out_t out_item_reg;

    // The parser steps when it has a beat and the result register will be free.
    logic      advance;
    logic      s_take;
    logic      res_valid;
    fcgi_out_t res;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign s_take  = s_valid && s_ready;

    fcgi_dmx_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (advance),
        .item      (in_item_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_take) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = res_valid;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_item_reg <= s_data;
        end
        if (advance && res_valid) begin
            out_item_reg <= res;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_item_reg;

`ifndef ASSERT_OFF
    // An empty result register must never hold off the input side.
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !out_valid_reg |-> s_ready)
        else $error("s_ready low with the result register empty");

    // A connection reset beat never produces an event.
    a_reset_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && (in_item_reg.operation == OP_RESET)) |=> !m_valid)
        else $error("event produced by a connection reset beat");

    // Only byte events carry a payload byte.
    a_payload_tag: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_data.payload_byte != 8'd0)) |->
        ((m_data.event_res == EV_STDIN_BYTE) || (m_data.event_res == EV_PARAMS_BYTE)))
        else $error("payload byte on a non-byte event");

    // Only begun and refused events carry a role.
    a_role_tag: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_data.role_value != 16'd0)) |->
        ((m_data.event_res == EV_BEGUN) || (m_data.event_res == EV_REFUSED)))
        else $error("role on an event other than begun or refused");
`endif

endmodule

// ===== src/fcgi_dmx_parser.sv =====
// Record parser state and its one-byte update step for the FastCGI demultiplexer.
// Depends on fcgi_dmx_pkg.
module fcgi_dmx_parser (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   step,
    input  fcgi_dmx_pkg::fcgi_in_t  item,
    output logic                   res_valid,
    output fcgi_dmx_pkg::fcgi_out_t res
);
    import fcgi_dmx_pkg::*;

    logic [1:0]  phase_reg, phase_next;
    logic [2:0]  header_index_reg, header_index_next;
    logic [7:0]  current_type_reg, current_type_next;
    logic [15:0] current_id_reg, current_id_next;
    logic [15:0] content_left_reg, content_left_next;
    logic [7:0]  padding_left_reg, padding_left_next;
    logic [1:0]  body_position_reg, body_position_next;
    logic [15:0] active_request_reg, active_request_next;
    logic [15:0] active_role_reg, active_role_next;

    logic        fin_go;
    logic [15:0] fin_role;
    logic [3:0]  ev;
    logic [7:0]  ev_payload;
    logic [15:0] ev_role;
    logic [15:0] content_dec;
    logic [7:0]  pad_dec;
    logic        skipped;
    logic [7:0]  b;
    logic [1:0]  after_content;

    always_comb begin
        phase_next          = phase_reg;
        header_index_next   = header_index_reg;
        current_type_next   = current_type_reg;
        current_id_next     = current_id_reg;
        content_left_next   = content_left_reg;
        padding_left_next   = padding_left_reg;
        body_position_next  = body_position_reg;
        active_request_next = active_request_reg;
        active_role_next    = active_role_reg;
        res_valid           = 1'b0;
        ev                  = EV_UNKNOWN;
        ev_payload          = 8'd0;
        ev_role             = 16'd0;
        fin_go              = 1'b0;
        fin_role            = 16'd0;
        b                   = item.data_byte;
        content_dec         = content_left_reg - 16'd1;
        pad_dec             = padding_left_reg - 8'd1;
        after_content       = (padding_left_reg != 8'd0) ? PH_PAD : PH_HEADER;
        skipped             = (current_id_reg == 16'd0) ||
                              ((active_request_reg != 16'd0) &&
                               (current_id_reg != active_request_reg));

        if (item.operation == OP_RESET) begin
            phase_next          = PH_HEADER;
            header_index_next   = 3'd0;
            current_type_next   = 8'd0;
            current_id_next     = 16'd0;
            content_left_next   = 16'd0;
            padding_left_next   = 8'd0;
            body_position_next  = BP_ROLE_HI;
            active_request_next = 16'd0;
            active_role_next    = 16'd0;
        end else begin
            case (phase_reg)
                PH_BODY: begin
                    if (content_left_reg == 16'd0) begin
                        phase_next = after_content;
                    end else begin
                        content_left_next = content_dec;
                        if (content_dec == 16'd0) begin
                            phase_next = after_content;
                        end
                        if (!skipped) begin
                            case (current_type_reg)
                                TY_STDIN: begin
                                    res_valid  = 1'b1;
                                    ev         = EV_STDIN_BYTE;
                                    ev_payload = b;
                                end
                                TY_PARAMS: begin
                                    res_valid  = 1'b1;
                                    ev         = EV_PARAMS_BYTE;
                                    ev_payload = b;
                                end
                                TY_BEGIN: begin
                                    if (body_position_reg == BP_ROLE_HI) begin
                                        active_role_next   = {b, 8'h00};
                                        body_position_next = BP_ROLE_LO;
                                        if (content_dec == 16'd0) begin
                                            fin_go   = 1'b1;
                                            fin_role = {b, 8'h00};
                                        end
                                    end else if (body_position_reg == BP_ROLE_LO) begin
                                        active_role_next = active_role_reg | {8'h00, b};
                                        fin_go           = 1'b1;
                                        fin_role         = active_role_reg | {8'h00, b};
                                    end
                                end
                                default: begin
                                end
                            endcase
                        end
                    end
                end
                PH_PAD: begin
                    if (padding_left_reg == 8'd0) begin
                        phase_next = PH_HEADER;
                    end else begin
                        padding_left_next = pad_dec;
                        if (pad_dec == 8'd0) begin
                            phase_next = PH_HEADER;
                        end
                    end
                end
                default: begin
                    phase_next = PH_HEADER;
                    case (header_index_reg)
                        HB_TYPE:    current_type_next = b;
                        HB_ID_HI:   current_id_next   = {b, 8'h00};
                        HB_ID_LO:   current_id_next   = {current_id_reg[15:8], b};
                        HB_LEN_HI:  content_left_next = {b, 8'h00};
                        HB_LEN_LO:  content_left_next = {content_left_reg[15:8], b};
                        HB_PAD_LEN: padding_left_next = b;
                        default: begin
                        end
                    endcase
                    if (header_index_reg == HB_LAST) begin
                        header_index_next = 3'd0;
                        if (content_left_reg != 16'd0) begin
                            phase_next = PH_BODY;
                        end else begin
                            phase_next = after_content;
                        end
                        if (current_id_reg == 16'd0) begin
                            res_valid = 1'b1;
                            ev = (current_type_reg == TY_GETVAL) ? EV_GETVAL : EV_UNKNOWN;
                        end else if (!skipped) begin
                            case (current_type_reg)
                                TY_BEGIN: begin
                                    active_request_next = current_id_reg;
                                    active_role_next    = 16'd0;
                                    body_position_next  = BP_ROLE_HI;
                                    if (content_left_reg == 16'd0) begin
                                        fin_go   = 1'b1;
                                        fin_role = 16'd0;
                                    end
                                end
                                TY_ABORT: begin
                                    active_request_next = 16'd0;
                                    active_role_next    = 16'd0;
                                    res_valid           = 1'b1;
                                    ev                  = EV_ABORT;
                                end
                                TY_PARAMS: begin
                                    if (content_left_reg == 16'd0) begin
                                        res_valid = 1'b1;
                                        ev        = EV_PARAMS_END;
                                    end
                                end
                                TY_STDIN: begin
                                    if (content_left_reg == 16'd0) begin
                                        res_valid = 1'b1;
                                        ev        = EV_STDIN_END;
                                    end
                                end
                                default: begin
                                    res_valid = 1'b1;
                                    ev        = EV_UNKNOWN;
                                end
                            endcase
                        end
                    end else begin
                        header_index_next = header_index_reg + 3'd1;
                    end
                end
            endcase
        end

        // The role is complete: accept the request or refuse a filter.
        if (fin_go) begin
            body_position_next = BP_DONE;
            res_valid          = 1'b1;
            ev_role            = fin_role;
            if (fin_role == ROLE_FILTER) begin
                ev                  = EV_REFUSED;
                active_request_next = 16'd0;
                active_role_next    = 16'd0;
            end else begin
                ev = EV_BEGUN;
            end
        end
    end

    always_comb begin
        res.event_res    = ev;
        res.request_id   = current_id_reg;
        res.record_type  = current_type_reg;
        res.payload_byte = ev_payload;
        res.role_value   = ev_role;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg          <= PH_HEADER;
            header_index_reg   <= 3'd0;
            current_type_reg   <= 8'd0;
            current_id_reg     <= 16'd0;
            content_left_reg   <= 16'd0;
            padding_left_reg   <= 8'd0;
            body_position_reg  <= BP_ROLE_HI;
            active_request_reg <= 16'd0;
            active_role_reg    <= 16'd0;
        end else if (step) begin
            phase_reg          <= phase_next;
            header_index_reg   <= header_index_next;
            current_type_reg   <= current_type_next;
            current_id_reg     <= current_id_next;
            content_left_reg   <= content_left_next;
            padding_left_reg   <= padding_left_next;
            body_position_reg  <= body_position_next;
            active_request_reg <= active_request_next;
            active_role_reg    <= active_role_next;
        end
    end

endmodule

// ===== tb/fastcgi_record_demux_unit_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for fastcgi_record_demux_unit: a table of FastCGI records, then
// random record streams, every result beat checked against a byte-level parser model
// or an event typed in the table. Depends on fcgi_dmx_pkg and the unit's RTL; needs no files or arguments.
module fastcgi_record_demux_unit_tb;
    import fcgi_dmx_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_BEATS = 600;
    localparam int DRAIN_CYCLES = 16;
    localparam int HOLD_FIRST   = 300;
    localparam int HOLD_STEP    = 450;
    localparam int HOLD_CYCLES  = 150;
    localparam int N_ROWS       = 24;

    localparam fcgi_out_t NO_EVENT = '0;

    // One record as the stimulus sees it. A connection-reset row is a single beat whose
    // data byte is taken from the version field. A nonzero cut truncates the record after
    // that many beats. Where fixed is set, the record's one event is typed in the table
    // and is due on the last header byte.
    typedef struct packed {
        logic        conn_reset;
        logic [7:0]  version;
        logic [7:0]  rec_type;
        logic [15:0] id;
        logic [15:0] body_len;
        logic [7:0]  pad_len;
        logic [7:0]  reserved;
        logic [15:0] body_head;
        logic [15:0] cut;
        logic        fixed;
        fcgi_out_t   want;
    } record_row_t;

    // One input beat waiting to be offered, with its typed expectation where there is one.
    typedef struct packed {
        fcgi_in_t  beat;
        logic      fixed;
        logic      fixed_here;
        fcgi_out_t want;
    } stream_beat_t;

    // How the result side behaves between long hold-offs.
    typedef enum logic [1:0] {RX_STREAM, RX_COIN, RX_SPARSE, RX_MOSTLY} rx_mode_t;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    fcgi_in_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    fcgi_out_t m_data;

    stream_beat_t pending_beats[$];
    fcgi_out_t    expected_events[$];
    stream_beat_t offered;
    record_row_t  directed_rows [N_ROWS];

    int error_count    = 0;
    int cycle_count    = 0;
    int beats_accepted = 0;
    int total_beats    = 0;
    int burst_left     = 1;
    int gap_left       = 0;
    int hold_left      = 0;
    int next_hold_at   = HOLD_FIRST;
    int mode_left      = 0;
    rx_mode_t rx_mode  = RX_STREAM;

    // Parser model state: record header fields, counters and the active request.
    logic [1:0]  prs_phase;
    logic [2:0]  hdr_pos;
    logic [7:0]  rec_type_q;
    logic [15:0] rec_id;
    logic [15:0] content_left;
    logic [7:0]  pad_left;
    logic [1:0]  begin_pos;
    logic [15:0] active_id;
    logic [15:0] active_role;

    always #5 aclk = ~aclk;

    fastcgi_record_demux_unit dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // ------------------------------------------------------------------------
    // Parser model
    // ------------------------------------------------------------------------

    function automatic fcgi_out_t event_of(logic [3:0] code, logic [7:0] payload,
                                           logic [15:0] role);
        fcgi_out_t e;
        e.event_res    = code;
        e.request_id   = rec_id;
        e.record_type  = rec_type_q;
        e.payload_byte = payload;
        e.role_value   = role;
        return e;
    endfunction

    task automatic clear_parser();
        prs_phase    = PH_HEADER;
        hdr_pos      = '0;
        rec_type_q   = '0;
        rec_id       = '0;
        content_left = '0;
        pad_left     = '0;
        begin_pos    = BP_ROLE_HI;
        active_id    = '0;
        active_role  = '0;
    endtask

    // Picks the next phase from the content and padding left in the current record.
    task automatic settle_phase();
        if (content_left != 16'h0000) begin
            prs_phase = PH_BODY;
        end else if (pad_left != 8'h00) begin
            prs_phase = PH_PAD;
        end else begin
            prs_phase = PH_HEADER;
        end
    endtask

    // The role is complete: a filter role is refused and drops the request.
    task automatic close_begin(output bit fired, output fcgi_out_t ev);
        logic [15:0] role;
        role      = active_role;
        begin_pos = BP_DONE;
        fired     = 1'b1;
        if (role == ROLE_FILTER) begin
            active_id   = '0;
            active_role = '0;
            ev = event_of(EV_REFUSED, 8'h00, role);
        end else begin
            ev = event_of(EV_BEGUN, 8'h00, role);
        end
    endtask

    task automatic close_header(output bit fired, output fcgi_out_t ev);
        fired = 1'b0;
        ev    = NO_EVENT;
        settle_phase();
        if (rec_id == 16'h0000) begin
            fired = 1'b1;
            ev = event_of((rec_type_q == TY_GETVAL) ? EV_GETVAL : EV_UNKNOWN, 8'h00, 16'h0000);
        end else if (active_id == 16'h0000 || rec_id == active_id) begin
            case (rec_type_q)
                TY_BEGIN: begin
                    active_id   = rec_id;
                    active_role = '0;
                    begin_pos   = BP_ROLE_HI;
                    if (content_left == 16'h0000) close_begin(fired, ev);
                end
                TY_ABORT: begin
                    active_id   = '0;
                    active_role = '0;
                    fired = 1'b1;
                    ev = event_of(EV_ABORT, 8'h00, 16'h0000);
                end
                TY_PARAMS: begin
                    if (content_left == 16'h0000) begin
                        fired = 1'b1;
                        ev = event_of(EV_PARAMS_END, 8'h00, 16'h0000);
                    end
                end
                TY_STDIN: begin
                    if (content_left == 16'h0000) begin
                        fired = 1'b1;
                        ev = event_of(EV_STDIN_END, 8'h00, 16'h0000);
                    end
                end
                default: begin
                    fired = 1'b1;
                    ev = event_of(EV_UNKNOWN, 8'h00, 16'h0000);
                end
            endcase
        end
    endtask

    task automatic take_body_byte(input logic [7:0] b, output bit fired, output fcgi_out_t ev);
        fired = 1'b0;
        ev    = NO_EVENT;
        if (content_left == 16'h0000) begin
            settle_phase();
            return;
        end
        content_left = content_left - 16'd1;
        if (content_left == 16'h0000) settle_phase();
        // Management records and records of a foreign request pass silently.
        if (rec_id == 16'h0000 || (active_id != 16'h0000 && rec_id != active_id)) return;
        case (rec_type_q)
            TY_STDIN: begin
                fired = 1'b1;
                ev = event_of(EV_STDIN_BYTE, b, 16'h0000);
            end
            TY_PARAMS: begin
                fired = 1'b1;
                ev = event_of(EV_PARAMS_BYTE, b, 16'h0000);
            end
            TY_BEGIN: begin
                if (begin_pos == BP_ROLE_HI) begin
                    active_role = {b, 8'h00};
                    begin_pos   = BP_ROLE_LO;
                    if (content_left == 16'h0000) close_begin(fired, ev);
                end else if (begin_pos == BP_ROLE_LO) begin
                    active_role = active_role | {8'h00, b};
                    close_begin(fired, ev);
                end
            end
            default: ;
        endcase
    endtask

    task automatic predict_beat(input fcgi_in_t beat, output bit fired, output fcgi_out_t ev);
        fired = 1'b0;
        ev    = NO_EVENT;
        if (beat.operation == OP_RESET) begin
            clear_parser();
            return;
        end
        if (prs_phase == PH_BODY) begin
            take_body_byte(beat.data_byte, fired, ev);
            return;
        end
        if (prs_phase == PH_PAD) begin
            if (pad_left != 8'h00) pad_left = pad_left - 8'd1;
            if (pad_left == 8'h00) prs_phase = PH_HEADER;
            return;
        end
        prs_phase = PH_HEADER;
        case (hdr_pos)
            HB_TYPE:    rec_type_q = beat.data_byte;
            HB_ID_HI:   rec_id = {beat.data_byte, 8'h00};
            HB_ID_LO:   rec_id[7:0] = beat.data_byte;
            HB_LEN_HI:  content_left = {beat.data_byte, 8'h00};
            HB_LEN_LO:  content_left[7:0] = beat.data_byte;
            HB_PAD_LEN: pad_left = beat.data_byte;
            default: ;
        endcase
        if (hdr_pos == HB_LAST) begin
            hdr_pos = '0;
            close_header(fired, ev);
        end else begin
            hdr_pos = hdr_pos + 3'd1;
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus construction
    // ------------------------------------------------------------------------

    // Turns one record into input beats: header, then body, then padding, cut short where the row sets a cut.
    task automatic queue_record(input record_row_t r);
        stream_beat_t sb;
        logic [63:0]  hdr;
        int           total;
        int           n;
        sb       = '0;
        sb.fixed = r.fixed;
        sb.want  = r.want;
        if (r.conn_reset) begin
            sb.beat.operation = OP_RESET;
            sb.beat.data_byte = r.version;
            pending_beats.push_back(sb);
            return;
        end
        hdr   = {r.version, r.rec_type, r.id, r.body_len, r.pad_len, r.reserved};
        total = 8 + int'(r.body_len) + int'(r.pad_len);
        if (r.cut != 16'd0 && int'(r.cut) < total) total = int'(r.cut);
        for (n = 0; n < total; n++) begin
            sb.beat.operation = OP_STREAM;
            if (n < 8) begin
                sb.beat.data_byte = hdr[63 - 8 * n -: 8];
            end else if (n == 8) begin
                sb.beat.data_byte = r.body_head[15:8];
            end else if (n == 9) begin
                sb.beat.data_byte = r.body_head[7:0];
            end else begin
                sb.beat.data_byte = 8'($urandom_range(0, 255));
            end
            sb.fixed_here = r.fixed && (n == 7);
            pending_beats.push_back(sb);
        end
    endtask

    function automatic record_row_t make_row(logic [7:0] rec_type, logic [15:0] id,
                                             logic [15:0] body_len, logic [7:0] pad_len);
        record_row_t r;
        r             = '0;
        r.version     = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : 8'd1;
        r.rec_type    = rec_type;
        r.id          = id;
        r.body_len    = body_len;
        r.pad_len     = pad_len;
        r.reserved    = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : 8'd0;
        r.body_head   = 16'($urandom_range(0, 65535));
        return r;
    endfunction

    function automatic record_row_t reset_row();
        record_row_t r;
        r            = '0;
        r.conn_reset = 1'b1;
        r.version    = 8'($urandom_range(0, 255));
        return r;
    endfunction

    // Mostly a handful of small ids so that sessions collide, now and then the extremes.
    function automatic logic [15:0] pick_id();
        case ($urandom_range(0, 5))
            0, 1, 2: return 16'($urandom_range(1, 3));
            3:       return 16'hFFFF;
            default: return 16'($urandom_range(1, 65535));
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Report and compare
    // ------------------------------------------------------------------------

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
        end
    endtask

    // ------------------------------------------------------------------------
    // Sender: offers the queued beats in bursts of random length with random gaps.
    // On every accepted beat the model is advanced and any event it raises is queued
    // as expected, unless the record's event is typed in the table.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        bit        fired;
        fcgi_out_t ev;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                predict_beat(s_data, fired, ev);
                if (offered.fixed) begin
                    if (offered.fixed_here) expected_events.push_back(offered.want);
                end else if (fired) begin
                    expected_events.push_back(ev);
                end
                beats_accepted++;
            end
            // A beat on offer must stay put until it is taken.
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (pending_beats.size() > 0) begin
                    offered = pending_beats.pop_front();
                    s_valid <= 1'b1;
                    s_data  <= offered.beat;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 60);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: switches between random stall patterns. At least twice in the run it
    // holds m_ready low for a long stretch while the sender keeps offering, so that
    // the unit fills up and has to drop s_ready.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (beats_accepted >= next_hold_at) begin
            next_hold_at += HOLD_STEP;
            hold_left = HOLD_CYCLES - 1;
            m_ready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                rx_mode   = rx_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(8, 64);
            end else begin
                mode_left--;
            end
            case (rx_mode)
                RX_STREAM: m_ready <= 1'b1;
                RX_COIN:   m_ready <= ($urandom_range(0, 1) == 1);
                RX_SPARSE: m_ready <= ($urandom_range(0, 3) == 0);
                default:   m_ready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Result checker: each result beat is compared with the oldest expectation.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        fcgi_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_events.size() == 0) begin
                report_mismatch($sformatf("unexpected event %0d, request %0h, type %0h",
                                          m_data.event_res, m_data.request_id,
                                          m_data.record_type));
            end else begin
                want = expected_events.pop_front();
                check_field("event_res", 16'(m_data.event_res), 16'(want.event_res));
                check_field("request_id", m_data.request_id, want.request_id);
                check_field("record_type", 16'(m_data.record_type), 16'(want.record_type));
                check_field("payload_byte", 16'(m_data.payload_byte),
                            16'(want.payload_byte));
                check_field("role_value", m_data.role_value, want.role_value);
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence: build the stimulus, release reset, wait for the last result.
    // ------------------------------------------------------------------------
    initial begin
        record_row_t row;
        logic [15:0] sess_id;
        int          directed_beats;
        int          pick;
        int          n_streams;
        int          k;

        clear_parser();

        // Directed records. The typed events are those raised on the last header byte.
        directed_rows = '{
            // GET_VALUES on the management id, empty and then with a body to skip.
            '{1'b0, 8'h01, TY_GETVAL, 16'h0000, 16'd0, 8'd0, 8'h00, 16'h0000, 16'd0,
              1'b1, '{EV_GETVAL, 16'h0000, TY_GETVAL, 8'h00, 16'h0000}},
            '{1'b0, 8'hFF, TY_GETVAL, 16'h0000, 16'd3, 8'd2, 8'hFF, 16'h1234, 16'd0,
              1'b1, '{EV_GETVAL, 16'h0000, TY_GETVAL, 8'h00, 16'h0000}},
            // Unknown management type at the top of the type range.
            '{1'b0, 8'h00, 8'hFF, 16'h0000, 16'd1, 8'd0, 8'h00, 16'hFF00, 16'd0,
              1'b1, '{EV_UNKNOWN, 16'h0000, 8'hFF, 8'h00, 16'h0000}},
            // A responder session on the highest id, with params and stdin streams.
            '{1'b0, 8'h01, TY_BEGIN, 16'hFFFF, 16'd8, 8'd0, 8'h00, 16'h0001, 16'd0,
              1'b0, NO_EVENT},
            '{1'b0, 8'h01, TY_PARAMS, 16'hFFFF, 16'd3, 8'd1, 8'h00, 16'h00FF, 16'd0,
              1'b0, NO_EVENT},
            '{1'b0, 8'h01, TY_PARAMS, 16'hFFFF, 16'd0, 8'd0, 8'h00, 16'h0000, 16'd0,
              1'b1, '{EV_PARAMS_END, 16'hFFFF, TY_PARAMS, 8'h00, 16'h0000}},
            // Stdin for another request is skipped without an event.
            '{1'b0, 8'h01, TY_STDIN, 16'h1234, 16'd2, 8'd0, 8'h00, 16'h5555, 16'd0,
              1'b0, NO_EVENT},
            '{1'b0, 8'h01, TY_STDIN, 16'hFFFF, 16'd4, 8'd3, 8'h00, 16'hFF00, 16'd0,
              1'b0, NO_EVENT},
            '{1'b0, 8'h01, TY_STDIN, 16'hFFFF, 16'd0, 8'd0, 8'h00, 16'h0000, 16'd0,
              1'b1, '{EV_STDIN_END, 16'hFFFF, TY_STDIN, 8'h00, 16'h0000}},
            // Type zero is not a known record type.
            '{1'b0, 8'h01, 8'h00, 16'hFFFF, 16'd0, 8'd0, 8'h00, 16'h0000, 16'd0,
              1'b1, '{EV_UNKNOWN, 16'hFFFF, 8'h00, 8'h00, 16'h0000}},
            // Abort with a body that is skipped; the session is closed.
            '{1'b0, 8'h01, TY_ABORT, 16'hFFFF, 16'd2, 8'd0, 8'h00, 16'hAAAA, 16'd0,
              1'b1, '{EV_ABORT, 16'hFFFF, TY_ABORT, 8'h00, 16'h0000}},
            // Begin with no body reports role zero at once.
            '{1'b0, 8'h01, TY_BEGIN, 16'h0001, 16'd0, 8'd0, 8'h00, 16'h0000, 16'd0,
              1'b1, '{EV_BEGUN, 16'h0001, TY_BEGIN, 8'h00, 16'h0000}},
            // Begin with only the high role byte, on the same id.
            '{1'b0, 8'h01, TY_BEGIN, 16'h0001, 16'd1, 8'd0, 8'h00, 16'hAB00, 16'd0,
              1'b0, NO_EVENT},
            // Abort and begin for other requests are ignored while one is active.
            '{1'b0, 8'h01, TY_ABORT, 16'h0007, 16'd0, 8'd0, 8'h00, 16'h0000, 16'd0,
              1'b0, NO_EVENT},
            '{1'b0, 8'h01, TY_BEGIN, 16'h0002, 16'd8, 8'd0, 8'h00, 16'h0002, 16'd0,
              1'b0, NO_EVENT},
            // Connection reset forgets the active request.
            '{1'b1, 8'h5A, 8'h00, 16'h0000, 16'd0, 8'd0, 8'h00, 16'h0000, 16'd0,
              1'b0, NO_EVENT},
            // The filter role is refused.
            '{1'b0, 8'h01, TY_BEGIN, 16'h0002, 16'd8, 8'd0, 8'h00, ROLE_FILTER, 16'd0,
              1'b0, NO_EVENT},
            // With no active request, stream records pass through.
            '{1'b0, 8'h01, TY_STDIN, 16'h0005, 16'd2, 8'd0, 8'h00, 16'h8001, 16'd0,
              1'b0, NO_EVENT},
            '{1'b0, 8'h01, 8'h0A, 16'h0005, 16'd0, 8'd0, 8'h00, 16'h0000, 16'd0,
              1'b1, '{EV_UNKNOWN, 16'h0005, 8'h0A, 8'h00, 16'h0000}},
            // Begin on the management id is an unknown management record.
            '{1'b0, 8'h01, TY_BEGIN, 16'h0000, 16'd0, 8'd0, 8'h00, 16'h0000, 16'd0,
              1'b1, '{EV_UNKNOWN, 16'h0000, TY_BEGIN, 8'h00, 16'h0000}},
            // A record broken off in its body, then a connection reset.
            '{1'b0, 8'h01, TY_STDIN, 16'h0003, 16'd5, 8'd2, 8'h00, 16'h7F80, 16'd10,
              1'b0, NO_EVENT},
            '{1'b1, 8'hFF, 8'h00, 16'h0000, 16'd0, 8'd0, 8'h00, 16'h0000, 16'd0,
              1'b0, NO_EVENT},
            // A role with the top bit set, then an abort to close the session.
            '{1'b0, 8'h01, TY_BEGIN, 16'h8001, 16'd2, 8'd0, 8'h00, 16'h8000, 16'd0,
              1'b0, NO_EVENT},
            '{1'b0, 8'h01, TY_ABORT, 16'h8001, 16'd0, 8'd0, 8'h00, 16'h0000, 16'd0,
              1'b1, '{EV_ABORT, 16'h8001, TY_ABORT, 8'h00, 16'h0000}}
        };
        for (k = 0; k < N_ROWS; k++) queue_record(directed_rows[k]);
        directed_beats = pending_beats.size();

        // Random traffic: mostly well-formed sessions with random content, the rest management
        // records, stray types, broken records, connection resets and long stream records.
        while (pending_beats.size() < directed_beats + RANDOM_BEATS) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                sess_id = pick_id();
                row = make_row(TY_BEGIN, sess_id,
                               ($urandom_range(0, 4) == 0) ? 16'($urandom_range(0, 3)) : 16'd8,
                               8'($urandom_range(0, 2)));
                case ($urandom_range(0, 9))
                    0:       row.body_head = ROLE_FILTER;
                    1:       row.body_head = 16'($urandom_range(0, 65535));
                    default: row.body_head = 16'($urandom_range(1, 2));
                endcase
                queue_record(row);
                n_streams = $urandom_range(1, 5);
                for (k = 0; k < n_streams; k++) begin
                    if ($urandom_range(0, 7) == 0) begin
                        queue_record(make_row(TY_STDIN, pick_id(), 16'($urandom_range(0, 4)),
                                              8'($urandom_range(0, 2))));
                    end
                    queue_record(make_row(($urandom_range(0, 1) == 1) ? TY_PARAMS : TY_STDIN,
                                          sess_id, 16'($urandom_range(0, 12)),
                                          8'($urandom_range(0, 3))));
                end
                queue_record(make_row(TY_PARAMS, sess_id, 16'd0, 8'd0));
                queue_record(make_row(TY_STDIN, sess_id, 16'd0, 8'd0));
                if ($urandom_range(0, 4) == 0) begin
                    queue_record(reset_row());
                end else begin
                    queue_record(make_row(TY_ABORT, sess_id, 16'($urandom_range(0, 2)), 8'd0));
                end
            end else if (pick < 70) begin
                queue_record(make_row(($urandom_range(0, 1) == 1) ? TY_GETVAL
                                                                   : 8'($urandom_range(0, 255)),
                                      16'h0000, 16'($urandom_range(0, 6)),
                                      8'($urandom_range(0, 2))));
            end else if (pick < 80) begin
                queue_record(make_row(8'($urandom_range(0, 255)), pick_id(),
                                      16'($urandom_range(0, 6)), 8'($urandom_range(0, 3))));
            end else if (pick < 93) begin
                // Line noise: a record with a random header broken off early, then a reset
                // so that a huge length does not swallow the rest of the run.
                row = make_row(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                               16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
                if ($urandom_range(0, 1) == 1) row.rec_type = TY_STDIN;
                row.cut = 16'($urandom_range(1, 12));
                queue_record(row);
                queue_record(reset_row());
            end else if (pick < 99) begin
                queue_record(reset_row());
            end else begin
                // A long stream record whose length may cross into the high byte.
                queue_record(make_row(($urandom_range(0, 1) == 1) ? TY_PARAMS : TY_STDIN,
                                      pick_id(), 16'($urandom_range(240, 270)),
                                      8'($urandom_range(0, 255))));
            end
        end
        total_beats = pending_beats.size();

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        while (beats_accepted < total_beats) @(posedge aclk);
        while (expected_events.size() != 0) @(posedge aclk);
        // Any stray result would show before the drain ends.
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
